// ===== hdl/tlqs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlqs_pkg
// Shared types, widths and codes of the two-level time-slice scheduler.
// ----------------------------------------------------------------------------
package tlqs_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_W            = 8;
   localparam int BURST_W         = 16;
   localparam int SLICE_W         = 8;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [SLICE_W-1:0] HIGH_SLICE_RESET = 8'd4;
   localparam logic [SLICE_W-1:0] LOW_SLICE_RESET  = 8'd2;
   localparam logic [SLICE_W-1:0] ELAPSED_MAX      = 8'd255;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_SLICE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_SLICE  = 1'd1;

   // queue levels
   localparam logic LEVEL_HIGH = 1'b0;
   localparam logic LEVEL_LOW  = 1'b1;

   // requeue causes
   localparam logic CAUSE_SLICE   = 1'b0;
   localparam logic CAUSE_PREEMPT = 1'b1;

   typedef struct packed {
      logic               arrival_valid;
      logic [ID_W-1:0]    arrival_id;
      logic               arrival_level;
      logic [BURST_W-1:0] arrival_burst;
   } req_type;

   typedef struct packed {
      logic            done_valid;
      logic [ID_W-1:0] done_id;
      logic            requeue_valid;
      logic [ID_W-1:0] requeue_id;
      logic            requeue_cause;
      logic            run_valid;
      logic [ID_W-1:0] run_id;
      logic            run_level;
      logic            run_new;
      logic            all_idle;
      logic            arrival_dropped;
   } rsp_type;

   // one queue slot: job id and remaining service time
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] remaining;
   } entry_type;

   // job holding the processor
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               level;
      logic [BURST_W-1:0] remaining;
      logic [SLICE_W-1:0] elapsed;
   } proc_type;

   // per-tick queue commands: push0 is the requeue, push1 the arrival
   typedef struct packed {
      logic      push0;
      entry_type push0_entry;
      logic      push1;
      entry_type push1_entry;
      logic      pop;
   } fifo_cmd_type;

endpackage

// ===== hdl/tlqs_fifo.sv =====
// ----------------------------------------------------------------------------
// tlqs_fifo
// Job queue with up to two pushes and one pop per cycle. The head entry is
// held in a register and is only meaningful while the queue is not empty.
// ----------------------------------------------------------------------------
module tlqs_fifo
   import tlqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  fifo_cmd_type  cmd,
   output logic [CW-1:0] count,
   output entry_type     head_entry
);

   localparam logic [PW:0]   DEPTH_W = (PW+1)'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST    = PW'(QUEUE_DEPTH - 1);

   entry_type     store [QUEUE_DEPTH];
   entry_type     head_entry_ff;
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW:0]   tail_sum;
   logic [PW-1:0] tail0, tail1, tail_arr;

   // tail position, wrapped by one compare and subtract
   assign tail_sum = {1'b0, head_ff} + (PW+1)'(count_ff);
   assign tail0    = (tail_sum >= DEPTH_W) ? PW'(tail_sum - DEPTH_W) : PW'(tail_sum);
   assign tail1    = (tail0 == LAST) ? '0 : tail0 + 1'b1;
   assign tail_arr = cmd.push0 ? tail1 : tail0;

   // pointer and occupancy update
   always_comb begin
      head_in  = head_ff;
      if (cmd.pop) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
      end
      count_in = count_ff + CW'(cmd.push0) + CW'(cmd.push1) - CW'(cmd.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // slot storage, no reset
   always_ff @(posedge clock) begin
      if (cmd.push0) begin
         store[tail0] <= cmd.push0_entry;
      end
      if (cmd.push1) begin
         store[tail_arr] <= cmd.push1_entry;
      end
   end

   // registered head; a slot written at this edge is taken from the push
   always_ff @(posedge clock) begin
      if (cmd.push0 && tail0 == head_in) begin
         head_entry_ff <= cmd.push0_entry;
      end else if (cmd.push1 && tail_arr == head_in) begin
         head_entry_ff <= cmd.push1_entry;
      end else begin
         head_entry_ff <= store[head_in];
      end
   end

   assign head_entry = head_entry_ff;
   assign count      = count_ff;

endmodule

// ===== hdl/tlqs_tick.sv =====
// ----------------------------------------------------------------------------
// tlqs_tick
// One scheduler tick: charge the running job, requeue or preempt, queue the
// arrival, dispatch. Produces queue commands, next processor state, result.
// ----------------------------------------------------------------------------
module tlqs_tick
   import tlqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic               fire,
   input  req_type            item,
   input  logic               busy,
   input  proc_type           cur,
   input  logic [SLICE_W-1:0] high_slice,
   input  logic [SLICE_W-1:0] low_slice,
   input  logic [CW-1:0]      hq_count,
   input  logic [CW-1:0]      lq_count,
   input  entry_type          hq_head,
   input  entry_type          lq_head,
   output fifo_cmd_type       hq_cmd,
   output fifo_cmd_type       lq_cmd,
   output logic               busy_next,
   output proc_type           cur_next,
   output rsp_type            result
);

   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   logic [BURST_W-1:0] rem1;
   logic [SLICE_W-1:0] el1;
   logic [SLICE_W-1:0] slice_len;
   logic [CW-1:0]      own_count;
   logic               rq_push, rq_level, arr_push;
   logic [CW-1:0]      hc2, lc2, hc3, lc3;
   logic               pop_h, pop_l;
   entry_type          rq_entry, arr_entry;
   entry_type          hq_front, lq_front;

   assign rem1      = (cur.remaining != '0) ? cur.remaining - 1'b1 : '0;
   assign el1       = (cur.elapsed < ELAPSED_MAX) ? cur.elapsed + 1'b1 : cur.elapsed;
   assign slice_len = (cur.level == LEVEL_LOW) ? low_slice : high_slice;
   assign own_count = (cur.level == LEVEL_LOW) ? lq_count : hq_count;
   assign rq_entry  = '{id: cur.id, remaining: rem1};
   assign arr_entry = '{id: item.arrival_id, remaining: item.arrival_burst};

   always_comb begin
      busy_next = busy;
      cur_next  = cur;
      result    = '0;
      rq_push   = 1'b0;
      rq_level  = cur.level;
      arr_push  = 1'b0;
      pop_h     = 1'b0;
      pop_l     = 1'b0;

      // charge the running job
      if (busy) begin
         cur_next.remaining = rem1;
         cur_next.elapsed   = el1;
         if (rem1 == '0) begin
            result.done_valid = 1'b1;
            result.done_id    = cur.id;
            busy_next         = 1'b0;
         end else if (el1 >= slice_len) begin
            if (own_count < DEPTH_C) begin
               rq_push              = 1'b1;
               result.requeue_valid = 1'b1;
               result.requeue_id    = cur.id;
               result.requeue_cause = CAUSE_SLICE;
               busy_next            = 1'b0;
            end else begin
               cur_next.elapsed = '0;
            end
         end
      end

      // high arrival preempts a low job
      if (item.arrival_valid && item.arrival_level == LEVEL_HIGH && busy_next &&
          cur.level == LEVEL_LOW && lq_count < DEPTH_C) begin
         rq_push              = 1'b1;
         rq_level             = LEVEL_LOW;
         result.requeue_valid = 1'b1;
         result.requeue_id    = cur.id;
         result.requeue_cause = CAUSE_PREEMPT;
         busy_next            = 1'b0;
      end

      hc2 = hq_count + CW'(rq_push && rq_level == LEVEL_HIGH);
      lc2 = lq_count + CW'(rq_push && rq_level == LEVEL_LOW);

      // queue the arrival
      if (item.arrival_valid) begin
         if ((item.arrival_level == LEVEL_LOW) ? (lc2 < DEPTH_C) : (hc2 < DEPTH_C)) begin
            arr_push = 1'b1;
         end else begin
            result.arrival_dropped = 1'b1;
         end
      end

      hc3 = hc2 + CW'(arr_push && item.arrival_level == LEVEL_HIGH);
      lc3 = lc2 + CW'(arr_push && item.arrival_level == LEVEL_LOW);

      // queue fronts; an empty queue offers this tick's first push
      hq_front = hq_head;
      if (hq_count == '0) begin
         hq_front = (rq_push && rq_level == LEVEL_HIGH) ? rq_entry : arr_entry;
      end
      lq_front = lq_head;
      if (lq_count == '0) begin
         lq_front = (rq_push && rq_level == LEVEL_LOW) ? rq_entry : arr_entry;
      end

      // dispatch to an idle processor
      if (!busy_next) begin
         if (hc3 != '0) begin
            pop_h              = 1'b1;
            cur_next.id        = hq_front.id;
            cur_next.remaining = hq_front.remaining;
            cur_next.level     = LEVEL_HIGH;
            cur_next.elapsed   = '0;
            busy_next          = 1'b1;
            result.run_new     = 1'b1;
         end else if (lc3 != '0) begin
            pop_l              = 1'b1;
            cur_next.id        = lq_front.id;
            cur_next.remaining = lq_front.remaining;
            cur_next.level     = LEVEL_LOW;
            cur_next.elapsed   = '0;
            busy_next          = 1'b1;
            result.run_new     = 1'b1;
         end
      end

      result.run_valid = busy_next;
      if (busy_next) begin
         result.run_id    = cur_next.id;
         result.run_level = cur_next.level;
      end
      result.all_idle = !busy_next && hc3 == '0 && lc3 == '0;
   end

   // queue commands, only on a processed tick
   always_comb begin
      hq_cmd.push0       = fire && rq_push && rq_level == LEVEL_HIGH;
      hq_cmd.push0_entry = rq_entry;
      hq_cmd.push1       = fire && arr_push && item.arrival_level == LEVEL_HIGH;
      hq_cmd.push1_entry = arr_entry;
      hq_cmd.pop         = fire && pop_h;
      lq_cmd.push0       = fire && rq_push && rq_level == LEVEL_LOW;
      lq_cmd.push0_entry = rq_entry;
      lq_cmd.push1       = fire && arr_push && item.arrival_level == LEVEL_LOW;
      lq_cmd.push1_entry = arr_entry;
      lq_cmd.pop         = fire && pop_l;
   end

endmodule

// ===== hdl/two_level_queue_time_slice_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_level_queue_time_slice_scheduler
// Two-level round-robin job scheduler, one tick per request transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ transfer is one time tick, optionally carrying an arriving job
//   (id, level, burst). Each tick yields exactly one rsp_ transfer reporting
//   completion, requeue, the job on the processor and queue drops.
//   csr_ writes set the high and low slice lengths; write only while idle.
// Timing: a transferred request is held in the input register, processed from
//   there and its result is registered in the result register.
// Throughput: one tick per cycle while results are taken; all work of a tick
//   sits between the input and result registers, with both queue pointers in flops.
// Stall: while the result is not taken, the held request waits in the input
//   register and req_ready drops once that register is occupied.
// Reset: both queues empty, processor idle, slices back to 4 and 2 ticks.
//   There is no clearing pass; queue slots are only read once written.
// ----------------------------------------------------------------------------
module two_level_queue_time_slice_scheduler
   import tlqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SLICE_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic               in_valid_ff, in_valid_in;
   req_type            in_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   logic               busy_ff, busy_in;
   proc_type           cur_ff, cur_in;
   logic               busy_next_w;
   proc_type           cur_next_w;
   logic [SLICE_W-1:0] high_slice_ff, low_slice_ff;
   logic               advance, fire;
   fifo_cmd_type       hq_cmd, lq_cmd;
   logic [CW-1:0]      hq_count, lq_count;
   entry_type          hq_head, lq_head;
   rsp_type            tick_result;

   // handshake control
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign fire         = in_valid_ff && advance;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= tick_result;
      end
   end

   // processor state
   assign busy_in = fire ? busy_next_w : busy_ff;
   assign cur_in  = fire ? cur_next_w  : cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cur_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cur_ff  <= cur_in;
      end
   end

   // slice length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_slice_ff <= HIGH_SLICE_RESET;
         low_slice_ff  <= LOW_SLICE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HIGH_SLICE: high_slice_ff <= csr_wdata;
            CSR_LOW_SLICE:  low_slice_ff  <= csr_wdata;
            default:        ;
         endcase
      end
   end

   tlqs_tick #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_tick (
      .fire       (fire),
      .item       (in_item_ff),
      .busy       (busy_ff),
      .cur        (cur_ff),
      .high_slice (high_slice_ff),
      .low_slice  (low_slice_ff),
      .hq_count   (hq_count),
      .lq_count   (lq_count),
      .hq_head    (hq_head),
      .lq_head    (lq_head),
      .hq_cmd     (hq_cmd),
      .lq_cmd     (lq_cmd),
      .busy_next  (busy_next_w),
      .cur_next   (cur_next_w),
      .result     (tick_result)
   );

   tlqs_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_high_q (
      .clock      (clock),
      .reset      (reset),
      .cmd        (hq_cmd),
      .count      (hq_count),
      .head_entry (hq_head)
   );

   tlqs_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_low_q (
      .clock      (clock),
      .reset      (reset),
      .cmd        (lq_cmd),
      .count      (lq_count),
      .head_entry (lq_head)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/tlqs_checker.sv =====
// ----------------------------------------------------------------------------
// tlqs_checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tlqs_checker
   import tlqs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic            prev_run_ff;
   logic [ID_W-1:0] prev_id_ff;

   // job on the processor as reported by the last result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_run_ff <= 1'b0;
         prev_id_ff  <= '0;
      end else if (rsp_valid && rsp_ready) begin
         prev_run_ff <= rsp_data.run_valid;
         prev_id_ff  <= rsp_data.run_id;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a transferred tick is followed by a valid result through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("no result two cycles after request transfer");

   // completion or requeue needs a job that was running
   a_release_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.done_valid || rsp_data.requeue_valid) |->
         prev_run_ff && (rsp_data.done_id == prev_id_ff ||
                         rsp_data.requeue_id == prev_id_ff))
      else $error("released job was not on the processor");

   // a job kept on the processor keeps its id
   a_run_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.run_valid && !rsp_data.run_new |->
         prev_run_ff && rsp_data.run_id == prev_id_ff)
      else $error("running job changed without dispatch");

endmodule

bind two_level_queue_time_slice_scheduler tlqs_checker u_tlqs_checker (.*);
